// ===== src/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types and constants of the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
package swarq_pkg;

	localparam int MAX_PACKETS_DEF = 4096;
	localparam int WINDOW_MAX_DEF  = 64;

	localparam int IDX_W  = 12;   // packet index field
	localparam int CNT_W  = 13;   // state counters, hold up to packet count plus one
	localparam int WIN_W  = 7;    // window length register
	localparam int ACKI_W = 13;   // signed ack/nack index
	localparam int ADDR_W = 3;

	// Register map, word index taken from paddr[2]
	localparam logic REG_NUM_PACKETS = 1'b0;
	localparam logic REG_WIN_LEN     = 1'b1;

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_TIMEOUT = 2'd1,
		ACT_ACK     = 2'd2,
		ACT_NACK    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_BURST = 2'b10
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic emit;    // load a result and update the state
		logic burst;   // produce the next packet of a start burst
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;   // result register empty or being taken
		logic res_last;   // result under evaluation closes its event
	} dp_status_t;

endpackage

// ===== src/swarq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swarq_ctrl
// Sequencer: takes one event at a time and steps a start burst.
// ----------------------------------------------------------------------------
module swarq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output swarq_pkg::dp_cmd_t    cmd,
	input  swarq_pkg::dp_status_t status
);
	import swarq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cmd.emit  = 1'b0;
		cmd.burst = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = status.out_free;
				if (s_tvalid && status.out_free) begin
					cmd.emit = 1'b1;
					if (!status.res_last)
						state_d = ST_BURST;
				end
			end
			ST_BURST: begin
				cmd.burst = 1'b1;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.res_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// no new event while a burst is in flight
	a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BURST) |-> !s_tready)
		else $error("event accepted during a start burst");

endmodule

// ===== src/swarq_dp.sv =====
// ----------------------------------------------------------------------------
// swarq_dp
// Window state, event evaluation and the result register.
// ----------------------------------------------------------------------------
module swarq_dp #(
	parameter int MAX_PACKETS = swarq_pkg::MAX_PACKETS_DEF,
	parameter int WINDOW_MAX  = swarq_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [swarq_pkg::IDX_W-1:0]   num_packets,
	input  logic [swarq_pkg::WIN_W-1:0]   win_len,
	input  logic [1:0]                    action,
	input  logic [swarq_pkg::ACKI_W-1:0]  ack_index,
	input  swarq_pkg::dp_cmd_t            cmd,
	output swarq_pkg::dp_status_t         status,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import swarq_pkg::*;

	localparam int CapInt = (MAX_PACKETS - 1 > 4095) ? 4095 : MAX_PACKETS - 1;
	localparam logic [IDX_W-1:0] N_CAP = IDX_W'(CapInt);
	localparam logic [WIN_W-1:0] W_CAP = WIN_W'(WINDOW_MAX);

	logic [CNT_W-1:0] nts_q, oua_q, nts_d, oua_d;
	logic [IDX_W-1:0] n;
	logic [CNT_W-1:0] n13, np1, idx13, nv;
	logic [WIN_W-1:0] w;
	logic             fin_now, res_valid, res_last, res_fin;
	logic [IDX_W-1:0] res_idx;
	action_t          act;
	logic [IDX_W-1:0] idx_q;
	logic             valid_q, fin_q, last_q, out_q;

	always_comb begin
		n = (num_packets > N_CAP) ? N_CAP : num_packets;
		w = (win_len > W_CAP) ? W_CAP : win_len;
		if ({{(IDX_W-WIN_W){1'b0}}, w} > n)
			w = n[WIN_W-1:0];
	end

	assign n13     = {1'b0, n};
	assign np1     = n13 + CNT_W'(1);
	assign idx13   = {1'b0, ack_index[IDX_W-1:0]};
	assign nv      = (idx13 + CNT_W'(1) > np1) ? np1 : idx13 + CNT_W'(1);
	assign fin_now = oua_q > n13;
	assign act     = cmd.burst ? ACT_START : action_t'(action);

	always_comb begin
		res_valid = 1'b0;
		res_idx   = '0;
		res_last  = 1'b1;
		nts_d     = nts_q;
		oua_d     = oua_q;
		if (!fin_now) begin
			case (act)
				ACT_START: begin
					if (nts_q <= {{(CNT_W-WIN_W){1'b0}}, w}) begin
						res_valid = 1'b1;
						res_idx   = nts_q[IDX_W-1:0];
						nts_d     = nts_q + CNT_W'(1);
						res_last  = (nts_q == {{(CNT_W-WIN_W){1'b0}}, w});
					end
				end
				ACT_TIMEOUT: begin
					res_valid = 1'b1;
					res_idx   = oua_q[IDX_W-1:0];
				end
				ACT_ACK: begin
					if (!ack_index[ACKI_W-1] && idx13 >= oua_q)
						oua_d = nv;
					if (nts_q <= n13) begin
						res_valid = 1'b1;
						res_idx   = nts_q[IDX_W-1:0];
						nts_d     = nts_q + CNT_W'(1);
					end
				end
				ACT_NACK: begin
					if (!ack_index[ACKI_W-1] && idx13 <= n13) begin
						res_valid = 1'b1;
						res_idx   = ack_index[IDX_W-1:0];
					end
				end
				default: ;
			endcase
		end
		res_fin = oua_d > n13;
	end

	assign status.out_free = !out_q || m_tready;
	assign status.res_last = res_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nts_q <= CNT_W'(1);
			oua_q <= '0;
			out_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				nts_q <= nts_d;
				oua_q <= oua_d;
				out_q <= 1'b1;
			end else if (m_tready) begin
				out_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			idx_q   <= res_idx;
			valid_q <= res_valid;
			fin_q   <= res_fin;
			last_q  <= res_last;
		end
	end

	assign m_tvalid = out_q;
	assign m_tdata  = {3'b000, fin_q, idx_q};
	assign m_tuser  = valid_q;
	assign m_tlast  = last_q;

	a_oldest_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		oua_q >= $past(oua_q))
		else $error("oldest unacknowledged index moved backwards");

	a_next_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		nts_q != '0)
		else $error("next packet index wrapped to zero");

	a_burst_sends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.burst) |=> (m_tvalid && m_tuser))
		else $error("burst step produced no transmission");

endmodule

// ===== src/sliding_window_arq_sender.sv =====
// ----------------------------------------------------------------------------
// sliding_window_arq_sender
// Sender side of a sliding-window ARQ scheme with ACK and NACK.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one link event (start, timeout, ack,
// nack); the master stream returns the packet transmissions it orders, one
// result per transmission, with tlast on the final one of the event. An event
// that orders nothing still yields one result with tuser low, so the finished
// flag in tdata[12] is always seen. Timeout, ack and nack give a single result;
// a start gives a burst of up to the window length in results, one per cycle
// while the output is not stalled, from the burst sequencer. A new event is
// taken only once the last result of the previous one is loaded into the
// output register. The user must write num_packets and the window length
// through the APB port only while no event is in flight; the block does not
// enforce this. The window is clamped to WINDOW_MAX and to the packet count.
module sliding_window_arq_sender #(
	parameter int MAX_PACKETS = swarq_pkg::MAX_PACKETS_DEF,
	parameter int WINDOW_MAX  = swarq_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// event stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [12:0] ack_index (signed)
	input  logic [1:0]                    s_tuser,   // [1:0] action
	// transmission stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [11:0] send_index, [12] finished
	output logic                          m_tuser,   // [0] send_valid
	output logic                          m_tlast,   // last result of the event
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swarq_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import swarq_pkg::*;

	logic [IDX_W-1:0] num_packets_q;
	logic [WIN_W-1:0] win_len_q;
	dp_cmd_t          cmd;
	dp_status_t       status;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register file: word index from paddr[2], low bits ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_packets_q <= IDX_W'(1);
			win_len_q     <= WIN_W'(1);
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_NUM_PACKETS: num_packets_q <= pwdata[IDX_W-1:0];
				REG_WIN_LEN:     win_len_q     <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUM_PACKETS: prdata = {{(32-IDX_W){1'b0}}, num_packets_q};
			REG_WIN_LEN:     prdata = {{(32-WIN_W){1'b0}}, win_len_q};
			default:         prdata = '0;
		endcase
	end

	// sequencer: hold off new events during a burst
	swarq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// window state and result register
	swarq_dp #(
		.MAX_PACKETS (MAX_PACKETS),
		.WINDOW_MAX  (WINDOW_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.num_packets (num_packets_q),
		.win_len     (win_len_q),
		.action      (s_tuser),
		.ack_index   (s_tdata[ACKI_W-1:0]),
		.cmd         (cmd),
		.status      (status),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule
